@@ design/sd_card_spi_host_engine_top_macros.svh @@
// Assertion macros for the SD SPI host engine.
`ifndef SD_CARD_SPI_HOST_ENGINE_TOP_MACROS_SVH
`define SD_CARD_SPI_HOST_ENGINE_TOP_MACROS_SVH

`define SDSPI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define SDSPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sdspi_pkg.sv @@
package sdspi_pkg;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_WAKE  = 4'd1,
    PH_READY = 4'd2,
    PH_FRAME = 4'd3,
    PH_RESP  = 4'd4,
    PH_R4    = 4'd5,
    PH_TOKEN = 4'd6,
    PH_DATA  = 4'd7,
    PH_DCRC  = 4'd8,
    PH_WGAP  = 4'd9,
    PH_WDATA = 4'd10,
    PH_WCRC  = 4'd11,
    PH_WRESP = 4'd12,
    PH_BUSY  = 4'd13,
    PH_TRAIL = 4'd14
  } phase_t;

  localparam logic [1:0] OP_XCHG  = 2'd0;
  localparam logic [1:0] OP_INIT  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  localparam logic [1:0] REG_RESP_POLL  = 2'd0;
  localparam logic [1:0] REG_READY_POLL = 2'd1;
  localparam logic [1:0] REG_IDLE_RETRY = 2'd2;
  localparam logic [1:0] REG_INIT_RETRY = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_IDLE   = 3'd1;
  localparam logic [2:0] ST_BAD_ECHO  = 3'd2;
  localparam logic [2:0] ST_INIT_TO   = 3'd3;
  localparam logic [2:0] ST_CMD_REJ   = 3'd4;
  localparam logic [2:0] ST_NO_TOKEN  = 3'd5;
  localparam logic [2:0] ST_WRITE_REJ = 3'd6;

  localparam logic [5:0] CMD0  = 6'd0;
  localparam logic [5:0] CMD8  = 6'd8;
  localparam logic [5:0] CMD9  = 6'd9;
  localparam logic [5:0] CMD17 = 6'd17;
  localparam logic [5:0] CMD24 = 6'd24;
  localparam logic [5:0] CMD41 = 6'd41;
  localparam logic [5:0] CMD55 = 6'd55;
  localparam logic [5:0] CMD58 = 6'd58;

  localparam logic [7:0] DATA_TOKEN = 8'hFE;
  localparam logic [7:0] IDLE_BYTE  = 8'hFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  miso_byte;
    logic [31:0] block_address;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  mosi_byte;
    logic        mosi_valid;
    logic        chip_select_high;
    logic        fast_clock;
    logic        data_wanted;
    logic [7:0]  read_data;
    logic        read_valid;
    logic        wait_one_ms;
    logic        done_res;
    logic [2:0]  status;
    logic        high_capacity;
    logic [31:0] block_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  response_poll_limit;
    logic [16:0] ready_poll_limit;
    logic [7:0]  idle_retry_limit;
    logic [11:0] init_retry_limit;
  } cfg_t;

endpackage

@@ design/sdspi_in_if.sv @@
interface sdspi_in_if;
  logic                 valid;
  logic                 ready;
  sdspi_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ design/sdspi_out_if.sv @@
interface sdspi_out_if;
  logic                  valid;
  logic                  ready;
  sdspi_pkg::out_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ design/sdspi_engine.sv @@
module sdspi_engine #(
  parameter int BLOCK_BYTES = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  sdspi_pkg::in_item_t  item,
  input  sdspi_pkg::cfg_t      cfg,
  output sdspi_pkg::out_item_t result
);

  localparam int BW = $clog2(BLOCK_BYTES) + 1;
  localparam int SH = $clog2(BLOCK_BYTES);

  sdspi_pkg::phase_t phase, phase_next;
  logic [16:0] poll_count, poll_count_next;
  logic [11:0] retry_count, retry_count_next;
  logic [BW-1:0] byte_index, byte_index_next;
  logic [2:0] frame_index, frame_index_next;
  logic [5:0] command_index, command_index_next;
  logic [31:0] command_argument, command_argument_next;
  logic version_two, version_two_next;
  logic capacity_flag, capacity_flag_next;
  logic [31:0] capacity_blocks, capacity_blocks_next;
  logic [21:0] size_field, size_field_next;
  logic clock_fast, clock_fast_next;

  logic [7:0] o_mosi, o_rdata;
  logic [2:0] o_status;
  logic o_valid, o_wanted, o_rvalid, o_wait, o_done;

  logic [7:0] m;
  logic [16:0] poll_inc;
  logic [11:0] retry_inc;
  logic [7:0] r1;
  logic do_cmd_done;
  logic [5:0] sc_idx;
  logic [31:0] sc_arg;
  logic do_start;
  logic do_frame;
  logic do_token;
  logic [7:0] tok;
  logic do_acmd;
  logic [2:0] fi_inc;
  logic [31:0] shifted;
  logic [BW-1:0] bi_inc;

  function automatic logic [7:0] frame_byte(input logic [2:0] i, input logic [5:0] ci,
                                            input logic [31:0] arg);
    logic [7:0] b;
    unique case (i)
      3'd0: b = {2'b01, ci};
      3'd1: b = arg[31:24];
      3'd2: b = arg[23:16];
      3'd3: b = arg[15:8];
      3'd4: b = arg[7:0];
      default: b = (ci == sdspi_pkg::CMD0) ? 8'h95 : (ci == sdspi_pkg::CMD8) ? 8'h87 : 8'h01;
    endcase
    return b;
  endfunction

  always_comb begin
    m = item.miso_byte;
    phase_next = phase;
    poll_count_next = poll_count;
    retry_count_next = retry_count;
    byte_index_next = byte_index;
    frame_index_next = frame_index;
    command_index_next = command_index;
    command_argument_next = command_argument;
    version_two_next = version_two;
    capacity_flag_next = capacity_flag;
    capacity_blocks_next = capacity_blocks;
    size_field_next = size_field;
    clock_fast_next = clock_fast;
    o_mosi = 8'h00; o_valid = 1'b0; o_wanted = 1'b0; o_rdata = 8'h00;
    o_rvalid = 1'b0; o_wait = 1'b0; o_done = 1'b0; o_status = sdspi_pkg::ST_OK;
    poll_inc = poll_count + 17'd1;
    retry_inc = retry_count + 12'd1;
    fi_inc = frame_index + 3'd1;
    bi_inc = byte_index + BW'(1);
    shifted = {command_argument[23:0], m};
    r1 = m;
    do_cmd_done = 1'b0;
    do_start = 1'b0; sc_idx = sdspi_pkg::CMD0; sc_arg = 32'd0;
    do_frame = 1'b0;
    do_token = 1'b0; tok = m;
    do_acmd = 1'b0;

    if (item.op == sdspi_pkg::OP_INIT) begin
      clock_fast_next = 1'b0;
      phase_next = sdspi_pkg::PH_WAKE;
      byte_index_next = BW'(1);
      o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
    end else if (item.op == sdspi_pkg::OP_READ || item.op == sdspi_pkg::OP_WRITE) begin
      do_start = 1'b1;
      sc_idx = (item.op == sdspi_pkg::OP_READ) ? sdspi_pkg::CMD17 : sdspi_pkg::CMD24;
      sc_arg = capacity_flag ? item.block_address : (item.block_address << SH);
    end else begin
      unique case (phase)
        sdspi_pkg::PH_WAKE: begin
          if (byte_index < BW'(10)) begin
            byte_index_next = bi_inc;
            o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
          end else begin
            retry_count_next = 12'd0;
            if (cfg.idle_retry_limit == 8'd0) begin
              phase_next = sdspi_pkg::PH_IDLE; o_done = 1'b1; o_status = sdspi_pkg::ST_NO_IDLE;
            end else begin
              do_start = 1'b1; sc_idx = sdspi_pkg::CMD0;
            end
          end
        end
        sdspi_pkg::PH_READY: begin
          poll_count_next = poll_inc;
          if (m == 8'hFF || poll_inc >= cfg.ready_poll_limit) do_frame = 1'b1;
          else begin o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1; end
        end
        sdspi_pkg::PH_FRAME: begin
          frame_index_next = fi_inc;
          if (fi_inc < 3'd6) begin
            o_mosi = frame_byte(fi_inc, command_index, command_argument); o_valid = 1'b1;
          end else begin
            poll_count_next = 17'd0;
            if (cfg.response_poll_limit == 8'd0) begin
              do_cmd_done = 1'b1; r1 = 8'hFF;
            end else begin
              phase_next = sdspi_pkg::PH_RESP;
              o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
            end
          end
        end
        sdspi_pkg::PH_RESP: begin
          poll_count_next = poll_inc;
          if (!m[7] || poll_inc >= {9'd0, cfg.response_poll_limit}) do_cmd_done = 1'b1;
          else begin o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1; end
        end
        sdspi_pkg::PH_R4: begin
          command_argument_next = shifted;
          byte_index_next = bi_inc;
          if (bi_inc < BW'(4)) begin
            o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
          end else if (command_index == sdspi_pkg::CMD8) begin
            if (shifted[15:0] != 16'h01AA) begin
              phase_next = sdspi_pkg::PH_IDLE; o_done = 1'b1; o_status = sdspi_pkg::ST_BAD_ECHO;
            end else begin
              version_two_next = 1'b1; do_acmd = 1'b1;
            end
          end else begin
            capacity_flag_next = shifted[30];
            capacity_blocks_next = 32'd0;
            do_start = 1'b1; sc_idx = sdspi_pkg::CMD9;
          end
        end
        sdspi_pkg::PH_TOKEN: begin
          poll_count_next = poll_inc;
          if (m != 8'hFF || poll_inc >= cfg.ready_poll_limit) do_token = 1'b1;
          else begin o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1; end
        end
        sdspi_pkg::PH_DATA: begin
          byte_index_next = bi_inc;
          if (command_index == sdspi_pkg::CMD9) begin
            if (byte_index == BW'(0)) command_argument_next = {31'd0, m[7:6] == 2'd1};
            else if (byte_index == BW'(7)) size_field_next = {m[5:0], 16'd0};
            else if (byte_index == BW'(8)) size_field_next = size_field | {6'd0, m, 8'd0};
            else if (byte_index == BW'(9)) size_field_next = size_field | {14'd0, m};
            if (bi_inc >= BW'(16)) begin
              phase_next = sdspi_pkg::PH_DCRC; frame_index_next = 3'd1;
            end
          end else begin
            o_rdata = m; o_rvalid = 1'b1;
            if (bi_inc >= BW'(BLOCK_BYTES)) begin
              phase_next = sdspi_pkg::PH_DCRC; frame_index_next = 3'd1;
            end
          end
          o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
        end
        sdspi_pkg::PH_DCRC: begin
          if (frame_index < 3'd2) begin
            frame_index_next = fi_inc;
            o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
          end else begin
            if (command_index == sdspi_pkg::CMD9 && command_argument == 32'd1)
              capacity_blocks_next = {size_field + 22'd1, 10'd0};
            phase_next = sdspi_pkg::PH_TRAIL; frame_index_next = sdspi_pkg::ST_OK;
            o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
          end
        end
        sdspi_pkg::PH_WGAP: begin
          phase_next = sdspi_pkg::PH_WDATA;
          byte_index_next = BW'(0);
          o_mosi = sdspi_pkg::DATA_TOKEN; o_valid = 1'b1; o_wanted = 1'b1;
        end
        sdspi_pkg::PH_WDATA: begin
          o_mosi = item.write_byte; o_valid = 1'b1;
          byte_index_next = bi_inc;
          if (bi_inc >= BW'(BLOCK_BYTES)) begin
            phase_next = sdspi_pkg::PH_WCRC; frame_index_next = 3'd0;
          end else o_wanted = 1'b1;
        end
        sdspi_pkg::PH_WCRC: begin
          frame_index_next = fi_inc;
          if (fi_inc >= 3'd3) phase_next = sdspi_pkg::PH_WRESP;
          o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
        end
        sdspi_pkg::PH_WRESP: begin
          if (m[4:0] != 5'h05) begin
            phase_next = sdspi_pkg::PH_IDLE; o_done = 1'b1; o_status = sdspi_pkg::ST_WRITE_REJ;
          end else begin
            poll_count_next = 17'd0;
            if (cfg.ready_poll_limit == 17'd0) begin
              phase_next = sdspi_pkg::PH_TRAIL; frame_index_next = sdspi_pkg::ST_OK;
            end else phase_next = sdspi_pkg::PH_BUSY;
            o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
          end
        end
        sdspi_pkg::PH_BUSY: begin
          poll_count_next = poll_inc;
          if (m == 8'hFF || poll_inc >= cfg.ready_poll_limit) begin
            phase_next = sdspi_pkg::PH_TRAIL; frame_index_next = sdspi_pkg::ST_OK;
          end
          o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
        end
        sdspi_pkg::PH_TRAIL: begin
          if (command_index == sdspi_pkg::CMD9) clock_fast_next = 1'b1;
          phase_next = sdspi_pkg::PH_IDLE; o_done = 1'b1; o_status = frame_index;
        end
        default: phase_next = sdspi_pkg::PH_IDLE;
      endcase
    end

    if (do_cmd_done) begin
      unique case (command_index)
        sdspi_pkg::CMD0: begin
          retry_count_next = retry_inc;
          if (r1 == 8'h01) begin
            do_start = 1'b1; sc_idx = sdspi_pkg::CMD8; sc_arg = 32'h1AA;
          end else if (retry_inc >= {4'd0, cfg.idle_retry_limit}) begin
            phase_next = sdspi_pkg::PH_IDLE; o_done = 1'b1; o_status = sdspi_pkg::ST_NO_IDLE;
          end else begin
            do_start = 1'b1; sc_idx = sdspi_pkg::CMD0;
          end
        end
        sdspi_pkg::CMD8: begin
          version_two_next = 1'b0;
          if (r1 == 8'h01) begin
            phase_next = sdspi_pkg::PH_R4; byte_index_next = BW'(0);
            command_argument_next = 32'd0;
            o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
          end else do_acmd = 1'b1;
        end
        sdspi_pkg::CMD55: begin
          do_start = 1'b1; sc_idx = sdspi_pkg::CMD41;
          sc_arg = version_two ? 32'h4000_0000 : 32'd0;
        end
        sdspi_pkg::CMD41: begin
          retry_count_next = retry_inc;
          o_wait = 1'b1;
          if (r1 == 8'h00) begin
            capacity_flag_next = 1'b0;
            do_start = 1'b1;
            if (version_two) sc_idx = sdspi_pkg::CMD58;
            else begin sc_idx = sdspi_pkg::CMD9; capacity_blocks_next = 32'd0; end
          end else if (retry_inc >= cfg.init_retry_limit) begin
            phase_next = sdspi_pkg::PH_IDLE; o_done = 1'b1; o_status = sdspi_pkg::ST_INIT_TO;
          end else begin
            do_start = 1'b1; sc_idx = sdspi_pkg::CMD55;
          end
        end
        sdspi_pkg::CMD58: begin
          if (r1 == 8'h00) begin
            phase_next = sdspi_pkg::PH_R4; byte_index_next = BW'(0);
            command_argument_next = 32'd0;
            o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
          end else begin
            capacity_blocks_next = 32'd0;
            do_start = 1'b1; sc_idx = sdspi_pkg::CMD9;
          end
        end
        sdspi_pkg::CMD9: begin
          if (r1 == 8'h00) do_token = 1'b1;
          else begin
            phase_next = sdspi_pkg::PH_TRAIL; frame_index_next = sdspi_pkg::ST_OK;
            o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
          end
        end
        sdspi_pkg::CMD17: begin
          if (r1 != 8'h00) begin
            phase_next = sdspi_pkg::PH_IDLE; o_done = 1'b1; o_status = sdspi_pkg::ST_CMD_REJ;
          end else do_token = 1'b1;
        end
        default: begin
          if (r1 != 8'h00) begin
            phase_next = sdspi_pkg::PH_IDLE; o_done = 1'b1; o_status = sdspi_pkg::ST_CMD_REJ;
          end else begin
            phase_next = sdspi_pkg::PH_WGAP;
            o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
          end
        end
      endcase
    end

    if (do_acmd) begin
      retry_count_next = 12'd0;
      if (cfg.init_retry_limit == 12'd0) begin
        phase_next = sdspi_pkg::PH_IDLE; o_done = 1'b1; o_status = sdspi_pkg::ST_INIT_TO;
      end else begin
        do_start = 1'b1; sc_idx = sdspi_pkg::CMD55;
      end
    end

    // token handling: command_index is not changed by anything else in this step
    if (do_token) begin
      poll_count_next = 17'd0;
      if (do_cmd_done && cfg.ready_poll_limit == 17'd0) tok = 8'hFF;
      if (do_cmd_done && cfg.ready_poll_limit != 17'd0) begin
        phase_next = sdspi_pkg::PH_TOKEN;
        o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
      end else if (tok == sdspi_pkg::DATA_TOKEN) begin
        phase_next = sdspi_pkg::PH_DATA;
        byte_index_next = BW'(0);
        if (command_index == sdspi_pkg::CMD9) command_argument_next = 32'd0;
        o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
      end else begin
        phase_next = sdspi_pkg::PH_TRAIL;
        frame_index_next = (command_index == sdspi_pkg::CMD9) ? sdspi_pkg::ST_OK
                                                             : sdspi_pkg::ST_NO_TOKEN;
        o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
      end
    end

    if (do_start) begin
      command_index_next = sc_idx;
      command_argument_next = sc_arg;
      poll_count_next = 17'd0;
      if (cfg.ready_poll_limit == 17'd0) do_frame = 1'b1;
      else begin
        phase_next = sdspi_pkg::PH_READY;
        o_mosi = sdspi_pkg::IDLE_BYTE; o_valid = 1'b1;
      end
    end

    if (do_frame) begin
      phase_next = sdspi_pkg::PH_FRAME;
      frame_index_next = 3'd0;
      o_mosi = frame_byte(3'd0, command_index_next, command_argument_next);
      o_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sdspi_pkg::PH_IDLE;
      poll_count <= '0; retry_count <= '0; byte_index <= '0; frame_index <= '0;
      command_index <= '0; command_argument <= '0; version_two <= 1'b0;
      capacity_flag <= 1'b0; capacity_blocks <= '0; size_field <= '0; clock_fast <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      poll_count <= poll_count_next; retry_count <= retry_count_next;
      byte_index <= byte_index_next; frame_index <= frame_index_next;
      command_index <= command_index_next; command_argument <= command_argument_next;
      version_two <= version_two_next; capacity_flag <= capacity_flag_next;
      capacity_blocks <= capacity_blocks_next; size_field <= size_field_next;
      clock_fast <= clock_fast_next;
    end
  end

  always_comb begin
    result.mosi_byte = o_mosi;
    result.mosi_valid = o_valid;
    result.chip_select_high = (phase_next == sdspi_pkg::PH_IDLE) ||
                              (phase_next == sdspi_pkg::PH_WAKE) ||
                              (phase_next == sdspi_pkg::PH_TRAIL);
    result.fast_clock = clock_fast_next;
    result.data_wanted = o_wanted;
    result.read_data = o_rdata;
    result.read_valid = o_rvalid;
    result.wait_one_ms = o_wait;
    result.done_res = o_done;
    result.status = o_status;
    result.high_capacity = capacity_flag_next;
    result.block_count = capacity_blocks_next;
  end

endmodule

@@ design/sd_card_spi_host_engine_top.sv @@
// SD card SPI-mode host engine. Each accepted beat is either a start request (init, block
// read, block write) or the MISO byte returned for the last MOSI byte; each produces one
// result beat naming the next MOSI byte, CS level and clock speed. One beat per cycle:
// all decisions are made in one pass through the sequencer logic and land in the result
// register, so a new beat is taken every cycle while the result side keeps up.
`include "sd_card_spi_host_engine_top_macros.svh"

module sd_card_spi_host_engine_top #(
  parameter int BLOCK_BYTES = 512
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [16:0]  cfg_data,
  sdspi_in_if.sink     in_ch,
  sdspi_out_if.source  out_ch
);

  sdspi_pkg::cfg_t cfg;
  sdspi_pkg::out_item_t result;
  logic step;
  logic out_valid;
  sdspi_pkg::out_item_t out_data;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign step = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.response_poll_limit <= 8'd12;
      cfg.ready_poll_limit <= 17'd100000;
      cfg.idle_retry_limit <= 8'd20;
      cfg.init_retry_limit <= 12'd2000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdspi_pkg::REG_RESP_POLL:  cfg.response_poll_limit <= cfg_data[7:0];
        sdspi_pkg::REG_READY_POLL: cfg.ready_poll_limit <= cfg_data;
        sdspi_pkg::REG_IDLE_RETRY: cfg.idle_retry_limit <= cfg_data[7:0];
        sdspi_pkg::REG_INIT_RETRY: cfg.init_retry_limit <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  sdspi_engine #(.BLOCK_BYTES(BLOCK_BYTES)) u_engine (
    .clk(clk), .rst(rst), .step(step), .item(in_ch.payload), .cfg(cfg), .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_data <= result;
  end

  assign out_ch.valid = out_valid;
  assign out_ch.payload = out_data;

  `SDSPI_ASSERT_NEXT(a_step_fills, clk, rst, step, out_valid, "accepted beat gave no result")
  `SDSPI_ASSERT_IMPL(a_stall_holds_in, clk, rst, out_valid && !out_ch.ready, !in_ch.ready,
    "input taken while result stalled")
  `SDSPI_ASSERT_IMPL(a_done_quiet, clk, rst, out_valid && out_data.done_res && !out_data.mosi_valid,
    out_data.chip_select_high, "request ended with CS low")

endmodule
